// ===== rtl/core/crp_pkg.sv =====
// Shared types and constants for the clock frame replacement block.
package crp_pkg;

   localparam int FRAMES_DEFAULT = 64;

   localparam int CFG_W   = 7;
   localparam int IDX_W   = 6;
   localparam int FRAME_W = 6;

   localparam logic [CFG_W-1:0] POOL_RESET = 7'd64;

   localparam logic ACT_ACCESS   = 1'b0;
   localparam logic ACT_ALLOCATE = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic access;
      logic fresh;
      logic start;
      logic scan;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_evict;
      logic scan_done;
   } dp_sts_type;

endpackage

// ===== rtl/core/clock_frame_replacement_top.sv =====
// Top level of the clock (second-chance) frame replacement block.
//
// Requests arrive on the req_ channel: req_action selects an access, which
// marks an in-use frame as referenced and gives no response, or an allocate,
// which gives one response on the rsp_ channel with the granted frame and
// whether it was taken from a resident page. csr_write_en loads the pool size.
// An allocate that finds a free frame has its response valid in the next
// cycle. An allocate that evicts sweeps the referenced-bit RAM from the hand,
// one frame per cycle through its registered read port, examining at most
// the frames in use (64 by default), and no request is taken meanwhile.
// The response sits in an output register; while rsp_stall holds it,
// req_stall is raised and no request is taken. Reset clears the use count,
// the hand and any pending response and loads the pool size to 64; no
// clearing pass is needed because a frame's bit is written when it is handed
// out.
module clock_frame_replacement_top #(
   parameter int FRAMES = crp_pkg::FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [crp_pkg::IDX_W-1:0]     req_frame_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [crp_pkg::FRAME_W-1:0]   rsp_granted_frame,
   output logic                          rsp_evicted,
   input  logic                          csr_write_en,
   input  logic [crp_pkg::CFG_W-1:0]     csr_write_data
);

   crp_pkg::dp_cmd_type cmd;
   crp_pkg::dp_sts_type sts;

   crp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   crp_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_frame_index   (req_frame_index),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_granted_frame (rsp_granted_frame),
      .rsp_evicted       (rsp_evicted)
   );

   // No request is taken while a sweep is running.
   a_scan_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> req_stall)
      else $error("request accepted during a sweep");

   // A sweep continues until the datapath reports a victim.
   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && !sts.scan_done) |=> cmd.scan)
      else $error("sweep ended without a victim");

   // A new response never overwrites one that is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && rsp_stall))
      else $error("pending response overwritten");

   // An access request never produces a response.
   a_access_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == crp_pkg::ACT_ACCESS) && !rsp_valid)
      |=> !rsp_valid)
      else $error("response after an access request");

endmodule

// ===== rtl/core/crp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = crp_pkg::FRAMES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/crp_ctrl.sv =====
// Controller state machine for the clock frame replacement block.
module crp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  crp_pkg::dp_sts_type    sts,
   output crp_pkg::dp_cmd_type    cmd
);

   crp_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff != crp_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crp_pkg::ST_IDLE: begin
            if (accept && (req_action == crp_pkg::ACT_ALLOCATE) && sts.need_evict) begin
               state_in = crp_pkg::ST_SCAN;
            end
         end
         crp_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = crp_pkg::ST_IDLE;
            end
         end
         default: state_in = crp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         crp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == crp_pkg::ACT_ACCESS) begin
                  cmd.access = 1'b1;
               end else if (!sts.need_evict) begin
                  cmd.fresh    = 1'b1;
                  cmd.load_rsp = 1'b1;
               end else begin
                  cmd.start = 1'b1;
               end
            end
         end
         crp_pkg::ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.load_rsp = sts.scan_done;
         end
         default: cmd = '0;
      endcase
   end

   // A result slot is only refilled once the previous one is gone or leaving.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/crp_datapath.sv =====
// Datapath: pool register, use count, clock hand, sweep pointers and result register.
module crp_datapath #(
   parameter int FRAMES = crp_pkg::FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [crp_pkg::IDX_W-1:0]     req_frame_index,
   input  logic                          csr_write_en,
   input  logic [crp_pkg::CFG_W-1:0]     csr_write_data,
   input  crp_pkg::dp_cmd_type           cmd,
   output crp_pkg::dp_sts_type           sts,
   output logic [crp_pkg::FRAME_W-1:0]   rsp_granted_frame,
   output logic                          rsp_evicted
);

   localparam int AW  = $clog2(FRAMES);
   localparam int FUW = $clog2(FRAMES + 1);
   localparam int LW  = (FUW > crp_pkg::CFG_W) ? FUW : crp_pkg::CFG_W;

   logic [crp_pkg::CFG_W-1:0] pool_ff, pool_in;
   logic [FUW-1:0]            used_ff, used_in;
   logic [AW-1:0]             hand_ff, hand_in;
   logic [AW-1:0]             start_ff, start_in;
   logic [AW-1:0]             rd_pos_ff, rd_pos_in;
   logic [AW-1:0]             iss_pos_ff, iss_pos_in;
   logic [FUW-1:0]            cnt_ff, cnt_in;
   logic [crp_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic                      evicted_ff, evicted_in;

   logic [LW-1:0] pool_ext, frames_ext, lim_cap, lim, used_ext, idx_ext, pos_ext;
   logic          idx_ok;
   logic [AW-1:0] h;
   logic          scan_last;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic          ram_rdata;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                              input logic [FUW-1:0] n);
      logic [FUW-1:0] s;
      s = FUW'(p) + FUW'(1);
      return (s == n) ? '0 : s[AW-1:0];
   endfunction

   // Usable pool is the register capped at FRAMES, with zero counting as one.
   assign pool_ext   = LW'(pool_ff);
   assign frames_ext = LW'(FRAMES);
   assign lim_cap    = (pool_ext > frames_ext) ? frames_ext : pool_ext;
   assign lim        = (lim_cap == '0) ? LW'(1) : lim_cap;
   assign used_ext   = LW'(used_ff);
   assign idx_ext    = LW'(req_frame_index);
   assign pos_ext    = LW'(rd_pos_ff);
   assign idx_ok     = idx_ext < used_ext;

   assign h         = (FUW'(hand_ff) < used_ff) ? hand_ff : '0;
   assign scan_last = (cnt_ff == (used_ff - FUW'(1)));

   assign sts.need_evict = used_ext >= lim;
   assign sts.scan_done  = !ram_rdata || scan_last;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = rd_pos_ff;
      ram_wdata = 1'b0;
      if (cmd.access) begin
         ram_we    = idx_ok;
         ram_waddr = idx_ext[AW-1:0];
         ram_wdata = 1'b1;
      end else if (cmd.fresh) begin
         ram_we    = 1'b1;
         ram_waddr = used_ff[AW-1:0];
      end else if (cmd.scan) begin
         // Second chance: a set bit is cleared as the hand passes it.
         ram_we = ram_rdata;
      end
   end

   assign ram_raddr = cmd.start ? h : iss_pos_ff;

   always_comb begin
      pool_in    = csr_write_en ? csr_write_data : pool_ff;
      used_in    = used_ff;
      hand_in    = hand_ff;
      start_in   = start_ff;
      rd_pos_in  = rd_pos_ff;
      iss_pos_in = iss_pos_ff;
      cnt_in     = cnt_ff;
      frame_in   = frame_ff;
      evicted_in = evicted_ff;
      if (cmd.fresh) begin
         used_in    = used_ff + FUW'(1);
         frame_in   = used_ext[crp_pkg::FRAME_W-1:0];
         evicted_in = 1'b0;
      end
      if (cmd.start) begin
         start_in   = h;
         rd_pos_in  = h;
         iss_pos_in = wrap_inc(h, used_ff);
         cnt_in     = '0;
      end
      if (cmd.scan) begin
         if (sts.scan_done) begin
            // If every bit was set the hand goes back to where it started.
            hand_in    = ram_rdata ? start_ff : rd_pos_ff;
            frame_in   = pos_ext[crp_pkg::FRAME_W-1:0];
            evicted_in = 1'b1;
         end else begin
            rd_pos_in  = iss_pos_ff;
            iss_pos_in = wrap_inc(iss_pos_ff, used_ff);
            cnt_in     = cnt_ff + FUW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= crp_pkg::POOL_RESET;
         used_ff <= '0;
         hand_ff <= '0;
      end else begin
         pool_ff <= pool_in;
         used_ff <= used_in;
         hand_ff <= hand_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      rd_pos_ff  <= rd_pos_in;
      iss_pos_ff <= iss_pos_in;
      cnt_ff     <= cnt_in;
      frame_ff   <= frame_in;
      evicted_ff <= evicted_in;
   end

   assign rsp_granted_frame = frame_ff;
   assign rsp_evicted       = evicted_ff;

   crp_ram #(
      .WIDTH (1),
      .DEPTH (FRAMES)
   ) u_ref_bits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
